>>> rtl/ufx_pkg.sv
package ufx_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  localparam logic [7:0] AsciiLimit = 8'h80;
  localparam logic [7:0] Mask3      = 8'hE0;
  localparam logic [7:0] Mask4      = 8'hF0;
  localparam logic [7:0] Mask5      = 8'hF8;
  localparam logic [7:0] Lead2      = 8'hC0;
  localparam logic [7:0] Lead3      = 8'hE0;
  localparam logic [7:0] Lead4      = 8'hF0;
  localparam logic [7:0] LineFeed   = 8'h0A;
  localparam logic [7:0] CarriageRet = 8'h0D;

  localparam logic [15:0] QuestionMark = 16'h003F;
  localparam logic [15:0] HighSurr     = 16'hD800;
  localparam logic [15:0] LowSurr      = 16'hDC00;
  localparam logic [20:0] SuppBase     = 21'h10000;
  localparam logic [20:0] UnitMax      = 21'h0FFFF;

  localparam logic [2:0] Len2 = 3'd2;
  localparam logic [2:0] Len3 = 3'd3;

  // Decoder state: bytes collected so far, sequence length, stored bytes.
  typedef struct packed {
    logic [1:0]      held;
    logic [2:0]      expected;
    logic [2:0][7:0] seq;
  } dec_state_t;

  typedef struct packed {
    dec_state_t st;
    logic [1:0] n;
    logic [15:0] u0;
    logic [15:0] u1;
  } dec_res_t;

  // Code units caused by one transaction, first unit in units[0].
  typedef struct packed {
    logic [1:0]       n;
    logic [2:0][15:0] units;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic dec_res_t dec_step(dec_state_t s, logic [7:0] b);
    dec_res_t   r;
    logic [20:0] cp;
    logic [20:0] v;
    logic [2:0]  held_n;
    r      = '0;
    r.st   = s;
    cp     = '0;
    v      = '0;
    held_n = {1'b0, s.held} + 3'd1;
    if (s.held == 2'd0) begin
      if (b < AsciiLimit) begin
        r.n  = 2'd1;
        r.u0 = {8'h00, b};
      end else begin
        r.st.seq[0] = b;
        r.st.held   = 2'd1;
        if ((b & Mask3) == Lead2) begin
          r.st.expected = 3'd2;
        end else if ((b & Mask4) == Lead3) begin
          r.st.expected = 3'd3;
        end else if ((b & Mask5) == Lead4) begin
          r.st.expected = 3'd4;
        end else begin
          r.st.held     = 2'd0;
          r.st.expected = 3'd0;
          r.n           = 2'd1;
          r.u0          = QuestionMark;
        end
      end
    end else if (held_n < s.expected) begin
      r.st.seq[s.held] = b;
      r.st.held        = held_n[1:0];
    end else begin
      if (s.expected == Len2) begin
        cp = {10'd0, s.seq[0][4:0], b[5:0]};
      end else if (s.expected == Len3) begin
        cp = {5'd0, s.seq[0][3:0], s.seq[1][5:0], b[5:0]};
      end else begin
        cp = {s.seq[0][2:0], s.seq[1][5:0], s.seq[2][5:0], b[5:0]};
      end
      r.st.held     = 2'd0;
      r.st.expected = 3'd0;
      if (cp > UnitMax) begin
        v    = cp - SuppBase;
        r.n  = 2'd2;
        r.u0 = HighSurr + {5'd0, v[20:10]};
        r.u1 = LowSurr + {6'd0, v[9:0]};
      end else begin
        r.n  = 2'd1;
        r.u0 = cp[15:0];
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/ufx_front.sv
module ufx_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [7:0]        data_byte_i,
  output logic              bundle_push_o,
  output ufx_pkg::bundle_t  bundle_o
);

  ufx_pkg::dec_state_t st_q, st_d, st_mid;
  ufx_pkg::dec_res_t   r1, r2;
  logic                expand_q, expand_d;
  logic                cr_first;
  logic [1:0]          n1;
  logic [2:0]          sum;

  always_comb begin
    cr_first = (data_byte_i == ufx_pkg::LineFeed) && expand_q;
    r1       = ufx_pkg::dec_step(st_q, ufx_pkg::CarriageRet);
    st_mid   = cr_first ? r1.st : st_q;
    r2       = ufx_pkg::dec_step(st_mid, data_byte_i);
    n1       = cr_first ? r1.n : 2'd0;
    sum      = {1'b0, n1} + {1'b0, r2.n};
    bundle_o.n = (sum > 3'd3) ? 2'd3 : sum[1:0];
    unique case (n1)
      2'd0: begin
        bundle_o.units[0] = r2.u0;
        bundle_o.units[1] = r2.u1;
        bundle_o.units[2] = '0;
      end
      2'd1: begin
        bundle_o.units[0] = r1.u0;
        bundle_o.units[1] = r2.u0;
        bundle_o.units[2] = r2.u1;
      end
      default: begin
        bundle_o.units[0] = r1.u0;
        bundle_o.units[1] = r1.u1;
        bundle_o.units[2] = r2.u0;
      end
    endcase
    bundle_push_o = take_i && (sum != 3'd0);
    st_d          = take_i ? r2.st : st_q;
    expand_d      = expand_q;
    if (take_i && (data_byte_i == ufx_pkg::CarriageRet)) begin
      expand_d = 1'b0;
    end else if (take_i && (data_byte_i == ufx_pkg::LineFeed)) begin
      expand_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= '0;
      expand_q <= 1'b1;
    end else begin
      st_q     <= st_d;
      expand_q <= expand_d;
    end
  end

endmodule

>>> rtl/ufx_fifo.sv
module ufx_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ufx_pkg::bundle_t    bundle_i,
  input  logic                pop_i,
  output ufx_pkg::bundle_t    head_o,
  output ufx_pkg::fifo_stat_t stat_o
);

  ufx_pkg::bundle_t                 mem [ufx_pkg::FifoDepth];
  logic [ufx_pkg::FifoAw-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [ufx_pkg::FifoAw:0]         cnt_q, cnt_d;

  always_comb begin
    stat_o.full  = (cnt_q == (ufx_pkg::FifoAw + 1)'(ufx_pkg::FifoDepth));
    stat_o.empty = (cnt_q == '0);
    head_o       = mem[rd_ptr_q];
    wr_ptr_d     = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d     = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d        = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= bundle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && stat_o.full |-> pop_i)
    else $error("bundle queue written while full");

  a_no_empty_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> bundle_i.n != 2'd0)
    else $error("bundle without code units queued");

endmodule

>>> rtl/ufx_back.sv
module ufx_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ufx_pkg::bundle_t    head_i,
  input  ufx_pkg::fifo_stat_t stat_i,
  input  logic                pop_i,
  output logic                empty_o,
  output logic [15:0]         code_unit_o,
  output logic                last_o,
  output logic                fifo_pop_o
);

  logic [1:0] k_q, k_d;
  logic       take;

  always_comb begin
    empty_o     = stat_i.empty;
    code_unit_o = head_i.units[k_q];
    last_o      = (k_q == head_i.n - 2'd1);
    take        = pop_i && !stat_i.empty;
    fifo_pop_o  = take && last_o;
    k_d         = k_q;
    if (take) begin
      k_d = last_o ? 2'd0 : k_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= 2'd0;
    end else begin
      k_q <= k_d;
    end
  end

  a_index_in_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stat_i.empty |-> k_q < head_i.n)
    else $error("unit index beyond bundle length");

endmodule

>>> rtl/utf8_to_utf16_crlf_expander.sv
// Each byte's code units are registered as a bundle and shown once it reaches the queue head.
// Throughput: one byte per cycle while not full; a byte that yields two or three code units
// holds the result port for one pop each, and a four-entry bundle queue absorbs the difference.
// Reset (rst_ni low, asynchronous): decoder idle, no open sequence, line-feed expansion on,
// queue empty. No clearing pass is needed; the block takes bytes right after reset.
module utf8_to_utf16_crlf_expander (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  data_byte_i,
  input  logic        push,
  output logic        full,
  output logic [15:0] code_unit_o,
  output logic        last_o,
  output logic        empty,
  input  logic        pop
);

  ufx_pkg::bundle_t    bundle, head;
  ufx_pkg::fifo_stat_t stat;
  logic                bundle_push;
  logic                fifo_pop;
  logic                take;

  // Hold input off while the bundle queue has no room, even for a byte that
  // would produce nothing: keeps the full flag a plain register decode.
  assign full = stat.full;
  assign take = push && !full;

  // Front: decode one byte per transaction, inserting a carriage return
  // ahead of a line feed when needed, and pack the resulting units.
  ufx_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .data_byte_i   (data_byte_i),
    .bundle_push_o (bundle_push),
    .bundle_o      (bundle)
  );

  // Queue of unit bundles between decoder and output sequencer.
  ufx_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (bundle_push),
    .bundle_i (bundle),
    .pop_i    (fifo_pop),
    .head_o   (head),
    .stat_o   (stat)
  );

  // Back: walk through the head bundle one code unit per transaction,
  // flag the final one, then advance the queue.
  ufx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .stat_i      (stat),
    .pop_i       (pop),
    .empty_o     (empty),
    .code_unit_o (code_unit_o),
    .last_o      (last_o),
    .fifo_pop_o  (fifo_pop)
  );

endmodule
